// File: hdl/hsl_pkg.sv
// Shared constants and types for the HSL to RGB converter pipeline.
package hsl_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int HUE_W         = 9;
    localparam int FAC_W         = 6;

    localparam logic [HUE_W-1:0] DEG_60   = HUE_W'(60);
    localparam logic [HUE_W-1:0] DEG_120  = HUE_W'(120);
    localparam logic [HUE_W-1:0] DEG_180  = HUE_W'(180);
    localparam logic [HUE_W-1:0] DEG_240  = HUE_W'(240);
    localparam logic [HUE_W-1:0] DEG_360  = HUE_W'(360);

    typedef logic [HUE_W-1:0] hue_t;

    // Which part of the hue circle a channel angle falls in.
    typedef enum logic [1:0] {
        REG_RISE,
        REG_HIGH,
        REG_FALL,
        REG_LOW
    } region_t;

endpackage

// File: hdl/hsl_front.sv
// Front stages: input clamping, hue rotation and the v1/v2 levels.
module hsl_front #(
    parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  hsl_pkg::hue_t            hue_degrees,
    input  logic [FRAC_BITS:0]       saturation,
    input  logic [FRAC_BITS:0]       lightness,
    output hsl_pkg::hue_t            d_red,
    output hsl_pkg::hue_t            d_green,
    output hsl_pkg::hue_t            d_blue,
    output logic [FRAC_BITS:0]       hi,
    output logic [FRAC_BITS:0]       lo,
    output logic [FRAC_BITS:0]       lit,
    output logic                     sat_zero
);

    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

    logic [W-1:0]  s_next, l_next, s_reg, l_reg;
    hsl_pkg::hue_t h_base;
    logic [hsl_pkg::HUE_W:0] h_red_sum, h_blue_sum;
    hsl_pkg::hue_t dr_next, dg_next, db_next;
    hsl_pkg::hue_t dr_reg, dg_reg, db_reg;

    logic [2*W-1:0] ls_full;
    logic [W-1:0]   prod;
    logic [W:0]     hi_wide, lo_wide;
    logic [W-1:0]   hi_next, lo_next, hi_reg, lo_reg, lit_reg;
    logic           sz_reg;

    // Stage one: clamp and rotate the hue for each channel.
    always_comb
    begin
        s_next = (saturation > ONE) ? ONE : saturation;
        l_next = (lightness > ONE) ? ONE : lightness;
        h_base = (hue_degrees >= hsl_pkg::DEG_360) ? hue_degrees - hsl_pkg::DEG_360
                                                   : hue_degrees;
        h_red_sum  = {1'b0, h_base} + {1'b0, hsl_pkg::DEG_120};
        h_blue_sum = {1'b0, h_base} + {1'b0, hsl_pkg::DEG_240};
        dr_next = (h_red_sum >= {1'b0, hsl_pkg::DEG_360})
                ? hsl_pkg::HUE_W'(h_red_sum - {1'b0, hsl_pkg::DEG_360})
                : h_red_sum[hsl_pkg::HUE_W-1:0];
        db_next = (h_blue_sum >= {1'b0, hsl_pkg::DEG_360})
                ? hsl_pkg::HUE_W'(h_blue_sum - {1'b0, hsl_pkg::DEG_360})
                : h_blue_sum[hsl_pkg::HUE_W-1:0];
        dg_next = h_base;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg  <= s_next;
            l_reg  <= l_next;
            dr_reg <= dr_next;
            dg_reg <= dg_next;
            db_reg <= db_next;
        end
    end

    // Stage two: one product, then the upper and lower levels.
    always_comb
    begin
        ls_full = {{W{1'b0}}, l_reg} * {{W{1'b0}}, s_reg};
        prod    = ls_full[FRAC_BITS +: W];
        if (l_reg < HALF)
            hi_wide = {1'b0, l_reg} + {1'b0, prod};
        else
            hi_wide = {1'b0, l_reg} + {1'b0, s_reg} - {1'b0, prod};
        lo_wide = {l_reg, 1'b0} - hi_wide;
        hi_next = hi_wide[W-1:0];
        lo_next = lo_wide[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg  <= hi_next;
            lo_reg  <= lo_next;
            lit_reg <= l_reg;
            sz_reg  <= (s_reg == '0);
        end
    end

    assign d_red    = dr_reg;
    assign d_green  = dg_reg;
    assign d_blue   = db_reg;
    assign hi       = hi_reg;
    assign lo       = lo_reg;
    assign lit      = lit_reg;
    assign sat_zero = sz_reg;

endmodule

// File: hdl/hsl_chan.sv
// One color channel: sector decode, ramp product, divide by 60 and final select.
module hsl_chan #(
    parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  hsl_pkg::hue_t      d,
    input  logic [FRAC_BITS:0] hi,
    input  logic [FRAC_BITS:0] lo,
    input  logic [FRAC_BITS:0] lit,
    input  logic               sat_zero,
    output logic [FRAC_BITS:0] value
);

    localparam int W  = FRAC_BITS + 1;
    localparam int XW = W + hsl_pkg::FAC_W;
    localparam int YW = XW - 2;
    // x/60 is (x>>2)/15, and the quotient by 15 is a reciprocal multiply.
    localparam int RN = FRAC_BITS + 8;
    localparam int KW = RN - 3;
    localparam longint unsigned KVAL = ((64'd1 << RN) / 15) + 1;
    localparam logic [KW-1:0] RECIP = KVAL[KW-1:0];

    hsl_pkg::region_t rg_next, rg2_reg, rg3_reg, rg4_reg;
    logic [hsl_pkg::FAC_W-1:0] fac_next, fac_reg;
    logic [W-1:0] hi3_reg, lo3_reg, hi4_reg, lo4_reg;
    logic [W-1:0] l3_reg, l4_reg;
    logic         z3_reg, z4_reg;
    logic [W-1:0] span;
    logic [XW-1:0] x_next, x_reg;
    logic [YW+KW-1:0] qprod;
    logic [W-1:0] q_next, q_reg;
    logic [W-1:0] val_next, val_reg;
    hsl_pkg::hue_t fall_fac;

    // Stage two: which sector, and the ramp weight within it.
    always_comb
    begin
        fall_fac = hsl_pkg::DEG_240 - d;
        if (d < hsl_pkg::DEG_60)
        begin
            rg_next  = hsl_pkg::REG_RISE;
            fac_next = d[hsl_pkg::FAC_W-1:0];
        end
        else if (d < hsl_pkg::DEG_180)
        begin
            rg_next  = hsl_pkg::REG_HIGH;
            fac_next = '0;
        end
        else if (d < hsl_pkg::DEG_240)
        begin
            rg_next  = hsl_pkg::REG_FALL;
            fac_next = fall_fac[hsl_pkg::FAC_W-1:0];
        end
        else
        begin
            rg_next  = hsl_pkg::REG_LOW;
            fac_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rg2_reg <= rg_next;
            fac_reg <= fac_next;
        end
    end

    // Stage three: span times weight.
    assign span   = hi - lo;
    assign x_next = {{hsl_pkg::FAC_W{1'b0}}, span} * {{W{1'b0}}, fac_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            rg3_reg <= rg2_reg;
            hi3_reg <= hi;
            lo3_reg <= lo;
            l3_reg  <= lit;
            z3_reg  <= sat_zero;
        end
    end

    // Stage four: quotient by 60.
    assign qprod  = {{KW{1'b0}}, x_reg[XW-1:2]} * {{YW{1'b0}}, RECIP};
    assign q_next = qprod[RN +: W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg   <= q_next;
            rg4_reg <= rg3_reg;
            hi4_reg <= hi3_reg;
            lo4_reg <= lo3_reg;
            l4_reg  <= l3_reg;
            z4_reg  <= z3_reg;
        end
    end

    // Stage five: pick the channel level.
    always_comb
    begin
        case (rg4_reg)
            hsl_pkg::REG_RISE: val_next = lo4_reg + q_reg;
            hsl_pkg::REG_HIGH: val_next = hi4_reg;
            hsl_pkg::REG_FALL: val_next = lo4_reg + q_reg;
            hsl_pkg::REG_LOW:  val_next = lo4_reg;
            default:           val_next = lo4_reg;
        endcase
        if (z4_reg)
            val_next = l4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            val_reg <= val_next;
    end

    assign value = val_reg;

endmodule

// File: hdl/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter: valid tracking and the three channels.
//
//  Port group | Direction | Handshake            | Words
//  -----------+-----------+----------------------+---------------------------------
//  input      | in        | in_valid / in_ready  | hue_degrees, saturation, lightness
//  output     | out       | out_valid / out_ready| red, green, blue
//
// One word enters per clock unless the pipeline holds; its result is presented from the final select stage.
// The five stages are clamp and hue rotation, the lightness-saturation product,
// the ramp product, the reciprocal multiply for the divide by 60, and the final select.
// Reset clears only the stage valid bits; data registers are left as they are.
// When the last stage holds a word that is not taken, the whole pipeline holds.
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hsl_pkg::hue_t       hue_degrees,
    input  logic [FRAC_BITS:0]  saturation,
    input  logic [FRAC_BITS:0]  lightness,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [FRAC_BITS:0]  red,
    output logic [FRAC_BITS:0]  green,
    output logic [FRAC_BITS:0]  blue
);

    localparam int DEPTH = 5;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic               en;
    logic [DEPTH-1:0]   vld_reg, vld_next;
    hsl_pkg::hue_t      d_red, d_green, d_blue;
    logic [FRAC_BITS:0] hi, lo, lit;
    logic               sat_zero;

    assign en = out_ready || !vld_reg[DEPTH-1];
    assign in_ready = en;
    assign vld_next = {vld_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    assign out_valid = vld_reg[DEPTH-1];

    hsl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk         (clk),
        .en          (en),
        .hue_degrees (hue_degrees),
        .saturation  (saturation),
        .lightness   (lightness),
        .d_red       (d_red),
        .d_green     (d_green),
        .d_blue      (d_blue),
        .hi          (hi),
        .lo          (lo),
        .lit         (lit),
        .sat_zero    (sat_zero)
    );

    hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
        .clk (clk), .en (en), .d (d_red), .hi (hi), .lo (lo), .lit (lit),
        .sat_zero (sat_zero), .value (red)
    );

    hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
        .clk (clk), .en (en), .d (d_green), .hi (hi), .lo (lo), .lit (lit),
        .sat_zero (sat_zero), .value (green)
    );

    hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
        .clk (clk), .en (en), .d (d_blue), .hi (hi), .lo (lo), .lit (lit),
        .sat_zero (sat_zero), .value (blue)
    );

    // The pipeline only stalls when a finished word is waiting at the output.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a blocked output word");

    // A stalled pipeline keeps every stage's occupancy.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("stage valid bits moved during a stall");

    // Every delivered channel lies within 0 to 1.0.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red <= ONE) && (green <= ONE) && (blue <= ONE))
        else $error("channel value above full scale");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the HSL to RGB converter with random handshake idling.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = hsl_pkg::FRAC_BITS_DEF;
    localparam longint unsigned ONE = longint'(1) << FB;
    localparam int RANDOM_WORDS = 1080;
    localparam int CALM_TAIL = 150;

    typedef logic [FB:0] level_t;

    typedef struct {
        hsl_pkg::hue_t hue;
        level_t        sat;
        level_t        light;
        int unsigned   gap;
        bit            drain_first;
    } hsl_word_t;

    typedef struct {
        level_t red;
        level_t green;
        level_t blue;
    } rgb_t;

    typedef struct {
        hsl_pkg::hue_t hue;
        level_t        sat;
        level_t        light;
        rgb_t          rgb;
    } rgb_expect_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    hsl_pkg::hue_t hue_degrees = '0;
    level_t        saturation = '0;
    level_t        lightness = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    level_t        red;
    level_t        green;
    level_t        blue;

    hsl_word_t   hsl_backlog[$];
    rgb_expect_t expected_rgb[$];

    int unsigned n_words = 0;
    int unsigned words_in = 0;
    int unsigned rgb_checked = 0;
    int unsigned mismatches = 0;
    int unsigned gray_words = 0;
    int unsigned clamped_words = 0;
    int unsigned gap_left = 0;
    bit          gap_done = 0;
    int unsigned stall_left = 0;
    int unsigned stall_pct = 0;

    hsl_to_rgb_converter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .hue_degrees (hue_degrees),
        .saturation  (saturation),
        .lightness   (lightness),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    always #1 clk = ~clk;

    // Level of one channel given the two bounds and its rotated hue angle.
    function automatic longint unsigned ramp_level(longint unsigned lo, longint unsigned hi,
                                                   longint unsigned angle);
        hsl_pkg::region_t zone;
        zone = (angle < 64'(hsl_pkg::DEG_60))  ? hsl_pkg::REG_RISE :
               (angle < 64'(hsl_pkg::DEG_180)) ? hsl_pkg::REG_HIGH :
               (angle < 64'(hsl_pkg::DEG_240)) ? hsl_pkg::REG_FALL : hsl_pkg::REG_LOW;
        case (zone)
            hsl_pkg::REG_RISE: return lo + ((hi - lo) * angle) / 64'(hsl_pkg::DEG_60);
            hsl_pkg::REG_HIGH: return hi;
            hsl_pkg::REG_FALL:
                return lo + ((hi - lo) * (64'(hsl_pkg::DEG_240) - angle))
                       / 64'(hsl_pkg::DEG_60);
            default: return lo;
        endcase
    endfunction

    function automatic rgb_t predict_rgb(hsl_pkg::hue_t hue, level_t sat, level_t light);
        longint unsigned h, s, l, prod, hi, lo;
        rgb_t res;
        h = 64'(hue);
        if (h >= 64'(hsl_pkg::DEG_360))
            h -= 64'(hsl_pkg::DEG_360);
        s = (64'(sat) > ONE) ? ONE : 64'(sat);
        l = (64'(light) > ONE) ? ONE : 64'(light);
        if (s == 0)
        begin
            res.red = level_t'(l);
            res.green = level_t'(l);
            res.blue = level_t'(l);
        end
        else
        begin
            prod = (l * s) >> FB;
            hi = (l < (ONE >> 1)) ? l + prod : l + s - prod;
            lo = 64'd2 * l - hi;
            res.red = level_t'(ramp_level(lo, hi,
                          (h + 64'(hsl_pkg::DEG_120)) % 64'(hsl_pkg::DEG_360)));
            res.green = level_t'(ramp_level(lo, hi, h));
            res.blue = level_t'(ramp_level(lo, hi,
                           (h + 64'(hsl_pkg::DEG_240)) % 64'(hsl_pkg::DEG_360)));
        end
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t ns: %s", $time, msg);
    endtask

    task automatic queue_word(input int unsigned hue, input int unsigned sat,
                              input int unsigned light, input int unsigned gap,
                              input bit drain_first);
        hsl_word_t w;
        w.hue = hsl_pkg::hue_t'(hue);
        w.sat = level_t'(sat);
        w.light = level_t'(light);
        w.gap = gap;
        w.drain_first = drain_first;
        if (w.sat == 0)
            gray_words++;
        if (64'(w.sat) > ONE || 64'(w.light) > ONE || w.hue >= hsl_pkg::DEG_360)
            clamped_words++;
        hsl_backlog.insert(hsl_backlog.size(), w);
    endtask

    // Saturation or lightness, weighted toward zero, one, the midpoint and the out-of-range codes.
    function automatic int unsigned pick_level();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 0;
        if (roll < 16)
            return 32'(ONE);
        if (roll < 26)
            return $urandom_range(32'(ONE + 1), 32'((ONE << 1) - 1));
        if (roll < 32)
            return $urandom_range(32'((ONE >> 1) - 2), 32'((ONE >> 1) + 1));
        return $urandom_range(0, 32'(ONE));
    endfunction

    // Driver: presents words from the backlog, honoring idle gaps and drain requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            hue_degrees <= '0;
            saturation <= '0;
            lightness <= '0;
            gap_left = 0;
            gap_done = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                rgb_expect_t taken;
                taken.hue = hue_degrees;
                taken.sat = saturation;
                taken.light = lightness;
                taken.rgb = predict_rgb(hue_degrees, saturation, lightness);
                expected_rgb.insert(expected_rgb.size(), taken);
                words_in++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (hsl_backlog.size() != 0 &&
                         !(hsl_backlog[0].drain_first && expected_rgb.size() != 0))
                begin
                    if (hsl_backlog[0].gap != 0 && !gap_done)
                    begin
                        gap_left = hsl_backlog[0].gap - 1;
                        gap_done = 1;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        hue_degrees <= hsl_backlog[0].hue;
                        saturation <= hsl_backlog[0].sat;
                        lightness <= hsl_backlog[0].light;
                        in_valid <= 1'b1;
                        void'(hsl_backlog.pop_front());
                        gap_done = 0;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted result word and throttles out_ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rgb.size() == 0)
                begin
                    note_mismatch($sformatf("result r=%0d g=%0d b=%0d with nothing pending",
                                            red, green, blue));
                end
                else
                begin
                    rgb_expect_t e;
                    e = expected_rgb.pop_front();
                    if (red !== e.rgb.red)
                        note_mismatch($sformatf("h=%0d s=%0d l=%0d red %0d, want %0d",
                                                e.hue, e.sat, e.light, red, e.rgb.red));
                    if (green !== e.rgb.green)
                        note_mismatch($sformatf("h=%0d s=%0d l=%0d green %0d, want %0d",
                                                e.hue, e.sat, e.light, green, e.rgb.green));
                    if (blue !== e.rgb.blue)
                        note_mismatch($sformatf("h=%0d s=%0d l=%0d blue %0d, want %0d",
                                                e.hue, e.sat, e.light, blue, e.rgb.blue));
                end
                rgb_checked++;
                if (rgb_checked % 64 == 0)
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 10;
                        default: stall_pct = 40;
                    endcase
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (rgb_checked + CALM_TAIL < n_words && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 9);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int unsigned gap_pct;
        int unsigned gap;
        int unsigned roll;
        int unsigned hue;

        // Sector edges, gray, full saturation, the lightness midpoint and clamped codes.
        queue_word(0, 0, 0, 0, 0);
        queue_word(0, 0, 4096, 0, 0);
        queue_word(359, 0, 2048, 0, 0);
        queue_word(0, 4096, 2048, 0, 0);
        queue_word(60, 4096, 2048, 0, 0);
        queue_word(120, 4096, 2048, 0, 0);
        queue_word(180, 4096, 2048, 0, 0);
        queue_word(240, 4096, 2048, 0, 0);
        queue_word(300, 4096, 2048, 0, 0);
        queue_word(59, 4096, 2047, 0, 0);
        queue_word(119, 4096, 4096, 0, 0);
        queue_word(179, 2048, 0, 0, 0);
        queue_word(239, 4095, 1, 0, 0);
        queue_word(359, 1, 4095, 0, 0);
        queue_word(360, 3000, 1000, 0, 0);
        queue_word(511, 5000, 3000, 0, 0);
        queue_word(30, 8191, 8191, 0, 0);
        queue_word(200, 4097, 2048, 0, 0);
        queue_word(90, 1234, 2048, 0, 0);
        queue_word(45, 4096, 2049, 0, 0);
        queue_word(150, 2731, 1365, 0, 0);
        queue_word(270, 4096, 3072, 0, 1);

        gap_pct = 0;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 100 == 0)
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 15;
                    default: gap_pct = 50;
                endcase
            gap = 0;
            if (i + CALM_TAIL < RANDOM_WORDS && $urandom_range(0, 99) < gap_pct)
                gap = $urandom_range(1, 10);
            roll = $urandom_range(0, 99);
            if (roll < 70)
                hue = $urandom_range(0, 359);
            else if (roll < 85)
                hue = $urandom_range(360, 511);
            else
                case ($urandom_range(0, 5))
                    0: hue = 59;
                    1: hue = 60;
                    2: hue = 179;
                    3: hue = 180;
                    4: hue = 239;
                    default: hue = 240;
                endcase
            queue_word(hue, pick_level(), pick_level(), gap, i == RANDOM_WORDS / 2);
        end
        n_words = hsl_backlog.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (hsl_backlog.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d words and checked %0d results: %0d gray, %0d with out-of-range codes.",
                 words_in, rgb_checked, gray_words, clamped_words);
        $display("Both sides idled in random bursts; the input drained the pipeline twice.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("Timeout with %0d results still pending.", expected_rgb.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/hsl_pkg.sv
hdl/hsl_front.sv
hdl/hsl_chan.sv
hdl/hsl_to_rgb_converter.sv
tb/sv/tb_top.sv
